### hdl/indexed_list_insert_delete_unit_defines.svh
// assertion macros shared by the indexed list unit
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

// property checked on every rising edge outside reset
`define ILID_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ILID_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ilid_pkg.sv
package ilid_pkg;

  localparam int DATA_W      = 32;
  localparam int IDX_W       = 8;
  localparam int CMD_W       = 3;
  localparam int ST_W        = 2;
  localparam int CAPACITY    = 64;
  localparam int GROUP       = 8;
  localparam int NUM_GROUPS  = (CAPACITY + GROUP - 1) / GROUP;
  localparam int IN_BITS     = CMD_W + IDX_W + DATA_W;
  localparam int OUT_BITS    = DATA_W + ST_W + IDX_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_HEAD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS_AT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  localparam logic [IDX_W-1:0] CAP_COUNT = IDX_W'(CAPACITY);

  // command broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

### hdl/ilid_cell.sv
module ilid_cell
  import ilid_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_pos,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] tap
);

  logic [DATA_W-1:0] data_next;

  // shift up on insert, down on delete, write at the insert position
  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (cell_pos == ctrl.pos) begin
        data_next = ctrl.value;
      end else if (cell_pos > ctrl.pos) begin
        data_next = left;
      end
    end else if (ctrl.del) begin
      if (cell_pos >= ctrl.pos) begin
        data_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // read tap: own entry when addressed, zero otherwise
  assign tap = (cell_pos == ctrl.pos) ? data : '0;

endmodule

### hdl/ilid_gather.sv
module ilid_gather
  import ilid_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] taps [GROUP],
  output logic [DATA_W-1:0] merged
);

  logic [DATA_W-1:0] merged_next;

  // or together the masked taps of one group
  always_comb begin
    merged_next = '0;
    for (int k = 0; k < GROUP; k++) begin
      merged_next = merged_next | taps[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      merged <= merged_next;
    end
  end

endmodule

### hdl/indexed_list_insert_delete_unit.sv
// Indexed list unit: an ordered list of signed 32-bit values, up to CAPACITY
// entries, held in a row of cells that shift as a whole.
// Input channel s_*: one command per transfer (read, insert at head, insert
// at tail, insert before index, delete at index).
// Output channel m_*: one result per command: read value (-1 unless a valid
// read), status (ok, invalid index, full) and the entry count after it.
// Results pass the pending stage, then the output register. One command per
// cycle is taken unless the receiver stalls. Each cell takes its new entry
// from itself, a neighbor or the command value in the same cycle; a read
// goes through a two-level or tree (group registers of eight, then output).
// Reset empties the list (count zero) and drops any command in flight.
// When the receiver stalls, the result waits in the output register, one
// more command is held in the stage before it, and s_tready then drops
// until m_tready returns.
`include "indexed_list_insert_delete_unit_defines.svh"

module indexed_list_insert_delete_unit
  import ilid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // command [2:0], index [10:3], value [42:11], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // read_value [31:0], status [33:32], length [41:34], zero fill above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  idx;
  logic [DATA_W-1:0] value;
  logic              s_xfer;
  logic              out_free;

  logic [IDX_W-1:0]  count;
  logic [IDX_W-1:0]  count_next;

  logic              is_ins;
  logic              ins_ok;
  logic              del_ok;
  logic              rd_ok;
  logic [IDX_W-1:0]  ins_pos;
  logic [ST_W-1:0]   status_next;
  cell_ctrl_t        ctrl;

  logic              pend_valid;
  logic              pend_read;
  logic [ST_W-1:0]   pend_status;
  logic [IDX_W-1:0]  pend_length;

  logic [DATA_W-1:0] read_sum;
  logic [DATA_W-1:0] out_value;
  logic [ST_W-1:0]   out_status;
  logic [IDX_W-1:0]  out_length;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_tap  [NUM_GROUPS*GROUP];
  logic [DATA_W-1:0] group_sum [NUM_GROUPS];

  // input unpacking
  assign cmd    = s_tdata[CMD_W-1:0];
  assign idx    = s_tdata[CMD_W+IDX_W-1:CMD_W];
  assign value  = s_tdata[CMD_W+IDX_W+DATA_W-1:CMD_W+IDX_W];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !pend_valid || out_free;
  assign s_xfer   = s_tvalid && s_tready;

  // command decode against the current count
  always_comb begin
    is_ins  = 1'b0;
    ins_pos = idx;
    rd_ok   = 1'b0;
    del_ok  = 1'b0;
    case (cmd)
      CMD_READ: begin
        rd_ok = (idx < count);
      end
      CMD_INS_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      CMD_INS_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = count;
      end
      CMD_INS_AT: begin
        is_ins  = 1'b1;
        ins_pos = idx;
      end
      CMD_DELETE: begin
        del_ok = (idx < count);
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
    ins_ok = is_ins && (ins_pos <= count) && (count < CAP_COUNT);

    if (is_ins) begin
      if (ins_pos > count) begin
        status_next = ST_INVALID;
      end else if (count >= CAP_COUNT) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
      end
    end else if (rd_ok || del_ok) begin
      status_next = ST_OK;
    end else begin
      status_next = ST_INVALID;
    end

    count_next = count;
    if (ins_ok) begin
      count_next = count + IDX_W'(1);
    end else if (del_ok) begin
      count_next = count - IDX_W'(1);
    end
  end

  // broadcast to the cell row, gated by the transfer
  assign ctrl.ins   = s_xfer && ins_ok;
  assign ctrl.del   = s_xfer && del_ok;
  assign ctrl.pos   = is_ins ? ins_pos : idx;
  assign ctrl.value = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s_xfer) begin
      count <= count_next;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = ctrl.value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    ilid_cell u_cell (
      .clk      (clk),
      .cell_pos (IDX_W'(i)),
      .ctrl     (ctrl),
      .left     (left_in),
      .right    (right_in),
      .data     (cell_data[i]),
      .tap      (cell_tap[i])
    );
  end

  // padding taps of the last group
  for (genvar i = CAPACITY; i < NUM_GROUPS * GROUP; i++) begin : g_pad
    assign cell_tap[i] = '0;
  end

  // first level of the read tree, one register per group
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    logic [DATA_W-1:0] grp_taps [GROUP];
    for (genvar k = 0; k < GROUP; k++) begin : g_tap
      assign grp_taps[k] = cell_tap[g*GROUP+k];
    end
    ilid_gather u_gather (
      .clk    (clk),
      .en     (s_xfer),
      .taps   (grp_taps),
      .merged (group_sum[g])
    );
  end

  // second level of the read tree
  always_comb begin
    read_sum = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      read_sum = read_sum | group_sum[g];
    end
  end

  // stage between the transfer and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_xfer) begin
      pend_valid <= 1'b1;
    end else if (out_free) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      pend_read   <= rd_ok;
      pend_status <= status_next;
      pend_length <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_valid) begin
      out_value  <= pend_read ? read_sum : '1;
      out_status <= pend_status;
      out_length <= pend_length;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - OUT_BITS)'(0), out_length, out_status, out_value};

  // checks
  `ILID_ASSERT(a_count_bound, count <= CAP_COUNT, "entry count above capacity")
  `ILID_ASSERT(a_full_len, (m_tvalid && out_status == ST_FULL) |-> out_length == CAP_COUNT, "full status with room left")
  `ILID_ASSERT(a_ins_grow, (s_xfer && ins_ok) |=> count == $past(count) + IDX_W'(1), "insert did not grow the list")
  `ILID_ASSERT(a_pend_hold, (pend_valid && !out_free) |=> pend_valid, "pending command lost")
  `ILID_ASSERT_ALWAYS(a_rst_empty, rst |=> (count == '0 && !m_tvalid), "reset left state behind")

endmodule
